// ----- rtl/jse_pkg.sv -----
// Package with the types, constants and helper functions of the Jacobi eigenvalue block.
`timescale 1ns / 1ps
package jse_pkg;

   // Port and internal widths.
   localparam int DATA_W  = 32;
   localparam int ENT_W   = 38;
   localparam int SUM_W   = 41;
   localparam int CF_W    = 31;
   localparam int CF_FRAC = 30;
   localparam int MUL_W   = 32;
   localparam int PROD_W  = 64;
   localparam int DEN_W   = 34;
   localparam int CNT_W   = 5;
   localparam int ROT_W   = 8;
   localparam int THR_W   = 31;

   // Positions of the six entries in the register bank.
   localparam int A_D0  = 0;
   localparam int A_D1  = 1;
   localparam int A_D2  = 2;
   localparam int A_O01 = 3;
   localparam int A_O02 = 4;
   localparam int A_O12 = 5;
   localparam int A_NUM = 6;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [ENT_W-1:0]  ent_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [ENT_W-1:0]         umag_type;
   typedef logic [CF_W-1:0]          coef_type;
   typedef logic [PROD_W-1:0]        prod_type;

   typedef struct packed {
      data_type diag_0;
      data_type diag_1;
      data_type diag_2;
      data_type off_01;
      data_type off_02;
      data_type off_12;
   } req_type;

   typedef struct packed {
      data_type eigen_low;
      data_type eigen_mid;
      data_type eigen_high;
   } rsp_type;

   // Configuration register indexes.
   typedef logic [0:0] csr_idx_type;
   localparam csr_idx_type CSR_MAX_ROT  = 1'b0;
   localparam csr_idx_type CSR_ZERO_THR = 1'b1;

   localparam logic [ROT_W-1:0] MAX_ROT_RESET  = 8'd50;
   localparam logic [THR_W-1:0] ZERO_THR_RESET = 31'd1;

   // Pivot position among the off-diagonal entries.
   typedef enum logic [1:0] {
      PIV_01,
      PIV_02,
      PIV_12
   } piv_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PIVOT,
      ST_NORM,
      ST_MUL_DD,
      ST_MUL_EE,
      ST_SQRT_LD,
      ST_SQRT_RUN,
      ST_T_DIV_LD,
      ST_DIV_RUN,
      ST_T_SQ,
      ST_C_SQRT_LD,
      ST_C_DIV_LD,
      ST_S_MUL,
      ST_TAU_DIV_LD,
      ST_UPD_TP,
      ST_MQ_HI,
      ST_MQ_LO,
      ST_UPD_PQ,
      ST_UPD_U1,
      ST_UPD_U2,
      ST_UPD_RP,
      ST_UPD_RQ,
      ST_SORT
   } seq_state_type;

   localparam sum_type ENT_LIM = sum_type'(1) <<< 36;

   // Clamp a wide sum to the entry range of plus or minus 2^36.
   function automatic ent_type sat_ent(input sum_type v);
      if (v > ENT_LIM) begin
         return ENT_W'(ENT_LIM);
      end else if (v < -ENT_LIM) begin
         return ENT_W'(-ENT_LIM);
      end
      return ENT_W'(v);
   endfunction

   // Magnitude of an entry.
   function automatic umag_type ent_mag(input ent_type v);
      return v[ENT_W-1] ? umag_type'(-v) : umag_type'(v);
   endfunction

   // Clamp an entry to the signed output range.
   function automatic data_type sat_out(input ent_type v);
      if (v > ent_type'({1'b0, {(DATA_W-1){1'b1}}})) begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v < -ent_type'({1'b0, 1'b1, {(DATA_W-1){1'b0}}})) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end
      return DATA_W'(v);
   endfunction

endpackage

// ----- rtl/jacobi_sym3_eigenvalues.sv -----
// Jacobi rotation eigenvalue engine for a symmetric 3x3 matrix with one shared multiplier.
// Each rotation runs the bit-serial square root twice and the divider three times.
// Throughput: one request at a time; the next request is taken once the result is queued.
// Reset: synchronous, active high; configuration returns to 50 rotations, threshold 1.
`timescale 1ns / 1ps
module jacobi_sym3_eigenvalues
   import jse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  csr_idx_type         csr_index,
   input  logic [THR_W-1:0]    csr_wdata
);

   seq_state_type state_ff, state_in, ret_ff;
   logic [ROT_W-1:0] max_rot_ff, rot_ff;
   logic [THR_W-1:0] zero_thr_ff;
   logic             rsp_valid_ff, rsp_load;
   rsp_type          rsp_data_ff;

   ent_type          a_ff [A_NUM];
   ent_type          ap_ff, aq_ff, apq_ff, arp_ff, arq_ff, u1_ff, u2_ff, mq_a_ff;
   piv_type          piv_ff;
   logic             neg_ff;
   umag_type         ud_ff, ue_ff;
   coef_type         tm_ff, cm_ff, sm_ff, tau_ff, mq_k_ff, q_ff;
   prod_type         prod_ff, acc_ff, sx_ff, sr_ff, sbit_ff;
   logic [DEN_W-1:0] rem_ff, den_ff;
   logic [CF_W-1:0]  nlo_ff;
   logic [CNT_W-1:0] cnt_ff;

   // Pivot search over the three off-diagonal entries.
   umag_type m01, m02, m12, mx;
   piv_type  piv_sel;
   logic     stop;
   ent_type  sel_ap, sel_aq, sel_apq, sel_arp, sel_arq;
   sum_type  d_s, e_s;

   always_comb begin
      m01 = ent_mag(a_ff[A_O01]);
      m02 = ent_mag(a_ff[A_O02]);
      m12 = ent_mag(a_ff[A_O12]);
      mx = m01;
      piv_sel = PIV_01;
      if (m02 > mx) begin
         mx = m02;
         piv_sel = PIV_02;
      end
      if (m12 > mx) begin
         mx = m12;
         piv_sel = PIV_12;
      end
      stop = (rot_ff == max_rot_ff) || (mx == '0) || (mx < umag_type'(zero_thr_ff));
      case (piv_sel)
         PIV_01: begin
            sel_ap = a_ff[A_D0]; sel_aq = a_ff[A_D1]; sel_apq = a_ff[A_O01];
            sel_arp = a_ff[A_O02]; sel_arq = a_ff[A_O12];
         end
         PIV_02: begin
            sel_ap = a_ff[A_D0]; sel_aq = a_ff[A_D2]; sel_apq = a_ff[A_O02];
            sel_arp = a_ff[A_O01]; sel_arq = a_ff[A_O12];
         end
         default: begin
            sel_ap = a_ff[A_D1]; sel_aq = a_ff[A_D2]; sel_apq = a_ff[A_O12];
            sel_arp = a_ff[A_O01]; sel_arq = a_ff[A_O02];
         end
      endcase
      d_s = sum_type'(sel_aq) - sum_type'(sel_ap);
      e_s = sum_type'(sel_apq) <<< 1;
   end

   // Shared multiplier operand selection; the product is registered every cycle.
   umag_type          mq_ua;
   logic [MUL_W-1:0]  op_a, op_b;

   always_comb begin
      mq_ua = ent_mag(mq_a_ff);
      case (state_ff)
         ST_MUL_DD: begin op_a = MUL_W'(ud_ff); op_b = MUL_W'(ud_ff); end
         ST_MUL_EE: begin op_a = MUL_W'(ue_ff); op_b = MUL_W'(ue_ff); end
         ST_T_SQ:   begin op_a = MUL_W'(q_ff);  op_b = MUL_W'(q_ff);  end
         ST_S_MUL:  begin op_a = MUL_W'(q_ff);  op_b = MUL_W'(tm_ff); end
         ST_MQ_HI:  begin op_a = MUL_W'(mq_ua[ENT_W-1:MUL_W]); op_b = MUL_W'(mq_k_ff); end
         ST_MQ_LO:  begin op_a = mq_ua[MUL_W-1:0]; op_b = MUL_W'(mq_k_ff); end
         default:   begin op_a = '0; op_b = '0; end
      endcase
   end

   // Rounded entry times coefficient from the two partial products.
   localparam prod_type ROUND_HALF = prod_type'(1) << (CF_FRAC - 1);
   sum_type mq_p, mq_res;

   always_comb begin
      mq_p = (sum_type'(acc_ff) <<< 2) + sum_type'((prod_ff + ROUND_HALF) >> CF_FRAC);
      mq_res = (mq_a_ff[ENT_W-1] ^ neg_ff) ? -mq_p : mq_p;
   end

   // Square root step, divider step and divider operand selection.
   prod_type          sq_trial;
   logic [DEN_W:0]    div_trial;
   logic              div_ge;
   prod_type          div_num;
   logic [DEN_W-1:0]  div_den;
   coef_type          sm_in;

   always_comb begin
      sq_trial  = sr_ff + sbit_ff;
      div_trial = {rem_ff, nlo_ff[CF_W-1]};
      div_ge    = div_trial >= {1'b0, den_ff};
      sm_in     = CF_W'((prod_ff + ROUND_HALF) >> CF_FRAC);
      case (state_ff)
         ST_T_DIV_LD: begin
            div_num = prod_type'(ue_ff[CF_W-1:0]) << CF_FRAC;
            div_den = DEN_W'(ud_ff) + DEN_W'(sr_ff);
         end
         ST_C_DIV_LD: begin
            div_num = prod_type'(1) << (2 * CF_FRAC);
            div_den = DEN_W'(sr_ff);
         end
         default: begin
            div_num = prod_type'(sm_in) << CF_FRAC;
            div_den = (DEN_W'(1) << CF_FRAC) + DEN_W'(cm_ff);
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_PIVOT;
         ST_PIVOT:      state_in = stop ? ST_SORT : ST_NORM;
         ST_NORM: begin
            if (!((|ud_ff[ENT_W-1:CF_W]) || (|ue_ff[ENT_W-1:CF_W]))) state_in = ST_MUL_DD;
         end
         ST_MUL_DD:     state_in = ST_MUL_EE;
         ST_MUL_EE:     state_in = ST_SQRT_LD;
         ST_SQRT_LD:    state_in = ST_SQRT_RUN;
         ST_SQRT_RUN:   if (sbit_ff[0]) state_in = ret_ff;
         ST_T_DIV_LD:   state_in = ST_DIV_RUN;
         ST_DIV_RUN:    if (cnt_ff == CNT_W'(CF_W - 1)) state_in = ret_ff;
         ST_T_SQ:       state_in = ST_C_SQRT_LD;
         ST_C_SQRT_LD:  state_in = ST_SQRT_RUN;
         ST_C_DIV_LD:   state_in = ST_DIV_RUN;
         ST_S_MUL:      state_in = ST_TAU_DIV_LD;
         ST_TAU_DIV_LD: state_in = ST_DIV_RUN;
         ST_MQ_HI:      state_in = ST_MQ_LO;
         ST_MQ_LO:      state_in = ret_ff;
         ST_UPD_TP, ST_UPD_PQ, ST_UPD_U1, ST_UPD_U2, ST_UPD_RP: state_in = ST_MQ_HI;
         ST_UPD_RQ:     state_in = ST_PIVOT;
         ST_SORT:       if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_load  = (state_ff == ST_SORT) && (!rsp_valid_ff || !rsp_stall);
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   // Sorting network on the diagonal and output saturation.
   ent_type v0, v1, v2, t0, t1, t2, w0, w1;

   always_comb begin
      t0 = (a_ff[A_D0] > a_ff[A_D1]) ? a_ff[A_D1] : a_ff[A_D0];
      t1 = (a_ff[A_D0] > a_ff[A_D1]) ? a_ff[A_D0] : a_ff[A_D1];
      w1 = (t1 > a_ff[A_D2]) ? a_ff[A_D2] : t1;
      t2 = (t1 > a_ff[A_D2]) ? t1 : a_ff[A_D2];
      v0 = (t0 > w1) ? w1 : t0;
      w0 = (t0 > w1) ? t0 : w1;
      v1 = w0;
      v2 = t2;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         rot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         max_rot_ff   <= MAX_ROT_RESET;
         zero_thr_ff  <= ZERO_THR_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MAX_ROT:  max_rot_ff  <= csr_wdata[ROT_W-1:0];
               CSR_ZERO_THR: zero_thr_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE) begin
            rot_ff <= '0;
         end else if (state_ff == ST_UPD_RQ) begin
            rot_ff <= rot_ff + 1'b1;
         end
         case (state_ff)
            ST_SQRT_LD:    ret_ff <= ST_T_DIV_LD;
            ST_T_DIV_LD:   ret_ff <= ST_T_SQ;
            ST_C_SQRT_LD:  ret_ff <= ST_C_DIV_LD;
            ST_C_DIV_LD:   ret_ff <= ST_S_MUL;
            ST_TAU_DIV_LD: ret_ff <= ST_UPD_TP;
            ST_UPD_TP:     ret_ff <= ST_UPD_PQ;
            ST_UPD_PQ:     ret_ff <= ST_UPD_U1;
            ST_UPD_U1:     ret_ff <= ST_UPD_U2;
            ST_UPD_U2:     ret_ff <= ST_UPD_RP;
            ST_UPD_RP:     ret_ff <= ST_UPD_RQ;
            default:       ret_ff <= ret_ff;
         endcase
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_type'(op_a) * prod_type'(op_b);
      if (rsp_load) begin
         rsp_data_ff.eigen_low  <= sat_out(v0);
         rsp_data_ff.eigen_mid  <= sat_out(v1);
         rsp_data_ff.eigen_high <= sat_out(v2);
      end
      case (state_ff)
         ST_IDLE: begin
            a_ff[A_D0]  <= ENT_W'(req_data.diag_0);
            a_ff[A_D1]  <= ENT_W'(req_data.diag_1);
            a_ff[A_D2]  <= ENT_W'(req_data.diag_2);
            a_ff[A_O01] <= ENT_W'(req_data.off_01);
            a_ff[A_O02] <= ENT_W'(req_data.off_02);
            a_ff[A_O12] <= ENT_W'(req_data.off_12);
         end
         ST_PIVOT: begin
            piv_ff <= piv_sel;
            ap_ff  <= sel_ap;
            aq_ff  <= sel_aq;
            apq_ff <= sel_apq;
            arp_ff <= sel_arp;
            arq_ff <= sel_arq;
            ud_ff  <= ENT_W'(d_s[SUM_W-1] ? -d_s : d_s);
            ue_ff  <= ENT_W'(e_s[SUM_W-1] ? -e_s : e_s);
            neg_ff <= d_s[SUM_W-1] != e_s[SUM_W-1];
         end
         ST_NORM: begin
            if ((|ud_ff[ENT_W-1:CF_W]) || (|ue_ff[ENT_W-1:CF_W])) begin
               ud_ff <= ud_ff >> 1;
               ue_ff <= ue_ff >> 1;
            end
         end
         ST_MUL_EE: acc_ff <= prod_ff;
         ST_SQRT_LD: begin
            sx_ff   <= acc_ff + prod_ff;
            sr_ff   <= '0;
            sbit_ff <= prod_type'(1) << (PROD_W - 2);
         end
         ST_C_SQRT_LD: begin
            sx_ff   <= (prod_type'(1) << (2 * CF_FRAC)) + prod_ff;
            sr_ff   <= '0;
            sbit_ff <= prod_type'(1) << (PROD_W - 2);
         end
         ST_SQRT_RUN: begin
            if (sx_ff >= sq_trial) begin
               sx_ff <= sx_ff - sq_trial;
               sr_ff <= (sr_ff >> 1) + sbit_ff;
            end else begin
               sr_ff <= sr_ff >> 1;
            end
            sbit_ff <= sbit_ff >> 2;
         end
         ST_T_DIV_LD, ST_C_DIV_LD, ST_TAU_DIV_LD: begin
            rem_ff <= DEN_W'(div_num >> CF_W);
            nlo_ff <= div_num[CF_W-1:0];
            den_ff <= div_den;
            cnt_ff <= '0;
            if (state_ff == ST_TAU_DIV_LD) sm_ff <= sm_in;
         end
         ST_DIV_RUN: begin
            rem_ff <= div_ge ? DEN_W'(div_trial - {1'b0, den_ff}) : DEN_W'(div_trial);
            q_ff   <= {q_ff[CF_W-2:0], div_ge};
            nlo_ff <= nlo_ff << 1;
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_T_SQ:  tm_ff <= q_ff;
         ST_S_MUL: cm_ff <= q_ff;
         ST_UPD_TP: begin
            tau_ff  <= q_ff;
            mq_a_ff <= apq_ff;
            mq_k_ff <= tm_ff;
         end
         ST_MQ_LO: acc_ff <= prod_ff;
         ST_UPD_PQ: begin
            ap_ff   <= sat_ent(sum_type'(ap_ff) - mq_res);
            aq_ff   <= sat_ent(sum_type'(aq_ff) + mq_res);
            mq_a_ff <= arp_ff;
            mq_k_ff <= tau_ff;
         end
         ST_UPD_U1: begin
            u1_ff   <= sat_ent(sum_type'(arq_ff) + mq_res);
            mq_a_ff <= arq_ff;
         end
         ST_UPD_U2: begin
            u2_ff   <= sat_ent(sum_type'(arp_ff) - mq_res);
            mq_a_ff <= u1_ff;
            mq_k_ff <= sm_ff;
         end
         ST_UPD_RP: begin
            arp_ff  <= sat_ent(sum_type'(arp_ff) - mq_res);
            mq_a_ff <= u2_ff;
         end
         ST_UPD_RQ: begin
            case (piv_ff)
               PIV_01: begin
                  a_ff[A_D0] <= ap_ff; a_ff[A_D1] <= aq_ff; a_ff[A_O01] <= '0;
                  a_ff[A_O02] <= arp_ff;
                  a_ff[A_O12] <= sat_ent(sum_type'(arq_ff) + mq_res);
               end
               PIV_02: begin
                  a_ff[A_D0] <= ap_ff; a_ff[A_D2] <= aq_ff; a_ff[A_O02] <= '0;
                  a_ff[A_O01] <= arp_ff;
                  a_ff[A_O12] <= sat_ent(sum_type'(arq_ff) + mq_res);
               end
               default: begin
                  a_ff[A_D1] <= ap_ff; a_ff[A_D2] <= aq_ff; a_ff[A_O12] <= '0;
                  a_ff[A_O01] <= arp_ff;
                  a_ff[A_O02] <= sat_ent(sum_type'(arq_ff) + mq_res);
               end
            endcase
         end
         default: ;
      endcase
   end

   // A taken request always starts with a pivot search.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_PIVOT))
      else $error("request taken without starting a pivot search");

   // The divider remainder stays below the divisor, so the quotient fits its width.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN) |-> (rem_ff < den_ff))
      else $error("divider remainder reached the divisor");

   // The first square root fits in 32 bits before it feeds the tangent divisor.
   a_sqrt_w: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_T_DIV_LD) |-> (sr_ff[PROD_W-1:MUL_W] == '0))
      else $error("square root result too wide");

   // The first diagonal entry and the 0-1 off-diagonal entry stay within the saturation range at each pivot search.
   a_ent_rng: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIVOT) |->
         (sum_type'(a_ff[A_D0]) <= ENT_LIM) && (sum_type'(a_ff[A_D0]) >= -ENT_LIM) &&
         (sum_type'(a_ff[A_O01]) <= ENT_LIM) && (sum_type'(a_ff[A_O01]) >= -ENT_LIM))
      else $error("matrix entry outside saturation range");

   // A result is only queued from the sort step.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_SORT))
      else $error("result raised outside the sort step");

endmodule
